[rtl/hfd_pkg.sv]
`default_nettype none
package hfd_pkg;

    localparam int HDR_BYTES   = 9;
    localparam int HDR_STORE_N = HDR_BYTES - 1;
    localparam int HDR_AW      = $clog2(HDR_STORE_N);
    localparam int CNT_W       = 4;
    localparam int LEN_W       = 24;
    localparam int SID_W       = 31;
    localparam int BYTE_W      = 8;

    localparam logic [6:0]       SID_TOP_MASK  = 7'h7f;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 24'd16384;

    // Result queue between the classifier and the output stage; power of two.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_PAYLOAD  = 2'd1,
        KIND_OVERSIZE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [LEN_W-1:0]   frame_length;
        logic [BYTE_W-1:0]  frame_type;
        logic [BYTE_W-1:0]  frame_flags;
        logic [SID_W-1:0]   stream_id;
        logic [BYTE_W-1:0]  data;
        logic               last;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage
`default_nettype wire

[rtl/hfd_front.sv]
`default_nettype none
module hfd_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [hfd_pkg::BYTE_W-1:0]   in_byte,
    input  wire logic                         cfg_we,
    input  wire logic [hfd_pkg::LEN_W-1:0]    cfg_data,
    output logic                              res_valid,
    output hfd_pkg::rec_t                     res
);

    logic [hfd_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [hfd_pkg::LEN_W-1:0]  left_reg, left_next;
    logic [hfd_pkg::LEN_W-1:0]  max_len_reg, max_len_next;
    logic [hfd_pkg::BYTE_W-1:0] hdr_reg [hfd_pkg::HDR_STORE_N];
    logic                       hdr_we;
    logic [hfd_pkg::LEN_W-1:0]  len;
    logic [hfd_pkg::SID_W-1:0]  sid;

    assign len = {hdr_reg[0], hdr_reg[1], hdr_reg[2]};
    assign sid = {hdr_reg[5][6:0] & hfd_pkg::SID_TOP_MASK, hdr_reg[6], hdr_reg[7], in_byte};

    assign max_len_next = cfg_we ? cfg_data : max_len_reg;

    always_comb
    begin
        count_next        = count_reg;
        left_next         = left_reg;
        hdr_we            = 1'b0;
        res_valid         = 1'b0;
        res.kind          = hfd_pkg::KIND_HEADER;
        res.frame_length  = len;
        res.frame_type    = hdr_reg[3];
        res.frame_flags   = hdr_reg[4];
        res.stream_id     = sid;
        res.data          = in_byte;
        res.last          = 1'b0;
        if (accept)
        begin
            if (left_reg != '0)
            begin
                // pass one payload byte
                res_valid = 1'b1;
                res.kind  = hfd_pkg::KIND_PAYLOAD;
                res.last  = (left_reg == hfd_pkg::LEN_W'(1));
                left_next = hfd_pkg::LEN_W'(left_reg - hfd_pkg::LEN_W'(1));
            end
            else if (count_reg < hfd_pkg::CNT_W'(hfd_pkg::HDR_STORE_N))
            begin
                hdr_we     = 1'b1;
                count_next = hfd_pkg::CNT_W'(count_reg + hfd_pkg::CNT_W'(1));
            end
            else
            begin
                // final header byte: decode and check the length
                res_valid  = 1'b1;
                count_next = '0;
                if (len > max_len_reg)
                begin
                    res.kind  = hfd_pkg::KIND_OVERSIZE;
                    left_next = '0;
                end
                else
                begin
                    res.last  = (len == '0);
                    left_next = len;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            left_reg    <= '0;
            max_len_reg <= hfd_pkg::MAX_LEN_RESET;
        end
        else
        begin
            count_reg   <= count_next;
            left_reg    <= left_next;
            max_len_reg <= max_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_reg[count_reg[hfd_pkg::HDR_AW-1:0]] <= in_byte;
        end
    end

endmodule
`default_nettype wire

[rtl/hfd_fifo.sv]
`default_nettype none
module hfd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire hfd_pkg::rec_t wr_data,
    input  wire logic          rd_en,
    output hfd_pkg::rec_t      rd_data,
    output hfd_pkg::fifo_stat_t stat
);

    hfd_pkg::rec_t              mem_reg [hfd_pkg::FIFO_DEPTH];
    logic [hfd_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [hfd_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [hfd_pkg::FIFO_AW:0]   count_reg, count_next;
    logic                        do_wr;
    logic                        do_rd;

    assign stat.full  = (count_reg == (hfd_pkg::FIFO_AW + 1)'(hfd_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? hfd_pkg::FIFO_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? hfd_pkg::FIFO_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = (hfd_pkg::FIFO_AW + 1)'(count_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = (hfd_pkg::FIFO_AW + 1)'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

[rtl/hfd_back.sv]
`default_nettype none
module hfd_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire hfd_pkg::rec_t               q_data,
    input  wire logic                        q_empty,
    output logic                             q_rd,
    input  wire logic                        pop,
    output logic                             empty,
    output logic [1:0]                       kind,
    output logic [hfd_pkg::LEN_W-1:0]        frame_length,
    output logic [hfd_pkg::BYTE_W-1:0]       frame_type,
    output logic [hfd_pkg::BYTE_W-1:0]       frame_flags,
    output logic [hfd_pkg::SID_W-1:0]        stream_id,
    output logic [hfd_pkg::BYTE_W-1:0]       payload_byte,
    output logic                             last
);

    logic          valid_reg, valid_next;
    hfd_pkg::rec_t out_reg, out_next;
    logic          is_payload;

    // refill from a non-empty queue whenever the output slot is free or being taken
    assign q_rd       = !q_empty && (!valid_reg || pop);
    assign is_payload = (q_data.kind == hfd_pkg::KIND_PAYLOAD);

    always_comb
    begin
        valid_next = valid_reg;
        out_next   = out_reg;
        if (pop && valid_reg)
        begin
            valid_next = 1'b0;
        end
        if (q_rd)
        begin
            valid_next            = 1'b1;
            out_next              = q_data;
            // drop header fields on payload bytes, data on everything else
            if (is_payload)
            begin
                out_next.frame_length = '0;
                out_next.frame_type   = '0;
                out_next.frame_flags  = '0;
                out_next.stream_id    = '0;
            end
            else
            begin
                out_next.data = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign empty        = !valid_reg;
    assign kind         = out_reg.kind;
    assign frame_length = out_reg.frame_length;
    assign frame_type   = out_reg.frame_type;
    assign frame_flags  = out_reg.frame_flags;
    assign stream_id    = out_reg.stream_id;
    assign payload_byte = out_reg.data;
    assign last         = out_reg.last;

endmodule
`default_nettype wire

[rtl/http2_frame_deframer.sv]
`default_nettype none
// HTTP/2 frame deframer: takes one stream byte per cycle while full is low
// (push/full) and returns header, payload-byte and oversize-length results
// in stream order (empty/pop). A frame's first eight bytes give nothing; the
// ninth gives a header or oversize result; each payload byte gives one
// result. Any mix of bytes sustains one byte per cycle while results are
// popped every cycle. The classifier writes a result into the four-entry
// result queue at the edge that accepts its byte, and the output register
// takes it from the queue once the output slot is free or being popped.
// full rises only when the result queue holds four results the consumer has
// not taken. max_payload_len is written through cfg_valid/cfg_data (cfg_ready
// is always high) and resets to 16384; write it only while the block is idle.
module http2_frame_deframer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [hfd_pkg::BYTE_W-1:0]   in_byte,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [hfd_pkg::LEN_W-1:0]    cfg_data,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [1:0]                        kind,
    output logic [hfd_pkg::LEN_W-1:0]         frame_length,
    output logic [hfd_pkg::BYTE_W-1:0]        frame_type,
    output logic [hfd_pkg::BYTE_W-1:0]        frame_flags,
    output logic [hfd_pkg::SID_W-1:0]         stream_id,
    output logic [hfd_pkg::BYTE_W-1:0]        payload_byte,
    output logic                              last
);

    logic                accept;
    logic                res_valid;
    hfd_pkg::rec_t       res;
    hfd_pkg::rec_t       q_data;
    hfd_pkg::fifo_stat_t q_stat;
    logic                q_rd;

    assign cfg_ready = 1'b1;
    assign full      = q_stat.full;
    assign accept    = push && !q_stat.full;

    hfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    hfd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .stat    (q_stat)
    );

    hfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_data),
        .q_empty      (q_stat.empty),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .kind         (kind),
        .frame_length (frame_length),
        .frame_type   (frame_type),
        .frame_flags  (frame_flags),
        .stream_id    (stream_id),
        .payload_byte (payload_byte),
        .last         (last)
    );

endmodule
`default_nettype wire

[rtl/hfd_checker.sv]
`default_nettype none
module hfd_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         empty,
    input  wire logic                         pop,
    input  wire logic [1:0]                   kind,
    input  wire logic [hfd_pkg::LEN_W-1:0]    frame_length,
    input  wire logic [hfd_pkg::SID_W-1:0]    stream_id,
    input  wire logic [hfd_pkg::BYTE_W-1:0]   payload_byte,
    input  wire logic                         last
);

    a_empty_in_reset: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(kind) && $stable(payload_byte) && $stable(last))
        else $error("stalled result changed");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind == hfd_pkg::KIND_PAYLOAD |-> frame_length == '0 && stream_id == '0)
        else $error("payload result carries header fields");

    a_empty_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind == hfd_pkg::KIND_HEADER |-> last == (frame_length == '0))
        else $error("header last flag does not match zero length");

    a_oversize_fields: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind == hfd_pkg::KIND_OVERSIZE |-> !last && payload_byte == '0 &&
        frame_length != '0)
        else $error("oversize result malformed");

endmodule

bind http2_frame_deframer hfd_checker u_hfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .kind         (kind),
    .frame_length (frame_length),
    .stream_id    (stream_id),
    .payload_byte (payload_byte),
    .last         (last)
);
`default_nettype wire
